FILE: rtl/llga_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the life-like grid automaton
package llga_pkg;

	localparam int KIND_W     = 2;
	localparam int ROW_W      = 4;
	localparam int COL_W      = 4;
	localparam int CNT_W      = 4;
	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 32;

	localparam logic [CNT_W-1:0] BIRTH_A_RST   = 4'd1;
	localparam logic [CNT_W-1:0] BIRTH_B_RST   = 4'd2;
	localparam logic [CNT_W-1:0] SURVIVE_A_RST = 4'd1;
	localparam logic [CNT_W-1:0] SURVIVE_B_RST = 4'd1;

	typedef enum logic [KIND_W-1:0] {
		REQ_WRITE   = 2'd0,
		REQ_READ    = 2'd1,
		REQ_ADVANCE = 2'd2
	} req_kind_t;

	typedef enum logic [1:0] {
		CFG_BIRTH_A   = 2'd0,
		CFG_BIRTH_B   = 2'd1,
		CFG_SURVIVE_A = 2'd2,
		CFG_SURVIVE_B = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CELL,
		ST_FILL,
		ST_LOAD,
		ST_SWEEP,
		ST_DONE
	} ctl_state_t;

	typedef struct packed {
		logic [CNT_W-1:0] birth_a;
		logic [CNT_W-1:0] birth_b;
		logic [CNT_W-1:0] survive_a;
		logic [CNT_W-1:0] survive_b;
	} rule_cfg_t;

	typedef struct packed {
		logic capture;
		logic rd_en;
		logic rd_cell;
		logic clr_prev;
		logic load_cur;
		logic sweep;
		logic last;
		logic push;
	} ctl_cmd_t;

	typedef struct packed {
		logic slot_free;
	} dp_status_t;

endpackage

FILE: rtl/llga_req_if.sv
`timescale 1ns / 1ps
// request channel: valid/ready handshake with cell request payload
interface llga_req_if import llga_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [KIND_W-1:0] req_type;
	logic [ROW_W-1:0]  cell_row;
	logic [COL_W-1:0]  cell_col;
	logic              write_alive;

	modport source (output valid, output req_type, output cell_row, output cell_col,
		output write_alive, input ready);
	modport sink (input valid, input req_type, input cell_row, input cell_col,
		input write_alive, output ready);
endinterface

FILE: rtl/llga_rsp_if.sv
`timescale 1ns / 1ps
// response channel: valid/ready handshake with completion payload
interface llga_rsp_if import llga_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              read_alive;
	logic [KIND_W-1:0] done_kind;

	modport source (output valid, output read_alive, output done_kind, input ready);
	modport sink (input valid, input read_alive, input done_kind, output ready);
endinterface

FILE: rtl/llga_cfg.sv
`timescale 1ns / 1ps
// apb register block holding the birth and survival counts
module llga_cfg import llga_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output rule_cfg_t             rules
);

	rule_cfg_t rules_q;
	logic      wr_en;
	cfg_reg_t  reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_sel = cfg_reg_t'(paddr[3:2]);
	assign rules   = rules_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rules_q.birth_a   <= BIRTH_A_RST;
			rules_q.birth_b   <= BIRTH_B_RST;
			rules_q.survive_a <= SURVIVE_A_RST;
			rules_q.survive_b <= SURVIVE_B_RST;
		end else if (wr_en) begin
			unique case (reg_sel)
				CFG_BIRTH_A:   rules_q.birth_a   <= pwdata[CNT_W-1:0];
				CFG_BIRTH_B:   rules_q.birth_b   <= pwdata[CNT_W-1:0];
				CFG_SURVIVE_A: rules_q.survive_a <= pwdata[CNT_W-1:0];
				CFG_SURVIVE_B: rules_q.survive_b <= pwdata[CNT_W-1:0];
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_sel)
			CFG_BIRTH_A:   prdata[CNT_W-1:0] = rules_q.birth_a;
			CFG_BIRTH_B:   prdata[CNT_W-1:0] = rules_q.birth_b;
			CFG_SURVIVE_A: prdata[CNT_W-1:0] = rules_q.survive_a;
			CFG_SURVIVE_B: prdata[CNT_W-1:0] = rules_q.survive_b;
		endcase
	end

endmodule

FILE: rtl/llga_ctrl.sv
`timescale 1ns / 1ps
// controller state machine sequencing cell accesses and generation sweeps
module llga_ctrl import llga_pkg::*; #(
	parameter int GRID_ROWS = 16,
	parameter int RA_W      = $clog2(GRID_ROWS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic [KIND_W-1:0] req_type,
	output logic              req_ready,
	input  dp_status_t        st,
	output ctl_cmd_t          cmd,
	output logic [RA_W-1:0]   rd_row,
	output logic [RA_W-1:0]   sweep_row
);

	ctl_state_t      state_q, state_d;
	logic [RA_W-1:0] row_q, row_d;
	logic            last_row;

	assign last_row  = (row_q == RA_W'(GRID_ROWS - 1));
	assign sweep_row = row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= '0;
		end else begin
			state_q <= state_d;
			row_q   <= row_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		row_d     = row_q;
		cmd       = '0;
		rd_row    = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					if (req_type == REQ_ADVANCE) begin
						state_d = ST_FILL;
					end else if (req_type == REQ_WRITE || req_type == REQ_READ) begin
						state_d = ST_CELL;
					end
				end
			end
			ST_CELL: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_cell = 1'b1;
				state_d     = ST_DONE;
			end
			ST_FILL: begin
				cmd.rd_en    = 1'b1;
				cmd.clr_prev = 1'b1;
				rd_row       = '0;
				state_d      = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.rd_en    = 1'b1;
				cmd.load_cur = 1'b1;
				rd_row       = RA_W'(1);
				row_d        = '0;
				state_d      = ST_SWEEP;
			end
			ST_SWEEP: begin
				cmd.sweep = 1'b1;
				cmd.last  = last_row;
				cmd.rd_en = ((32'(row_q) + 32'd2) < 32'(GRID_ROWS));
				rd_row    = row_q + RA_W'(2);
				row_d     = row_q + RA_W'(1);
				if (last_row) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (st.slot_free) begin
					cmd.push = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/llga_datapath.sv
`timescale 1ns / 1ps
// grid row memory, row buffers, next-generation logic and result register
module llga_datapath import llga_pkg::*; #(
	parameter int GRID_ROWS = 16,
	parameter int GRID_COLS = 16,
	parameter int RA_W      = $clog2(GRID_ROWS),
	parameter int CA_W      = $clog2(GRID_COLS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ctl_cmd_t          cmd,
	input  logic [RA_W-1:0]   rd_row,
	input  logic [RA_W-1:0]   sweep_row,
	output dp_status_t        st,
	input  rule_cfg_t         rules,
	input  logic [KIND_W-1:0] req_type,
	input  logic [ROW_W-1:0]  cell_row,
	input  logic [COL_W-1:0]  cell_col,
	input  logic              write_alive,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output logic              read_alive,
	output logic [KIND_W-1:0] done_kind
);

	logic [GRID_COLS-1:0] mem_q [GRID_ROWS];
	logic [GRID_ROWS-1:0] row_valid_q;
	logic [GRID_COLS-1:0] rd_data_s1;
	logic                 rd_zero_s1;

	logic [KIND_W-1:0] kind_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic              wv_q;

	logic [GRID_COLS-1:0] prev_q, cur_q;
	logic                 rsp_valid_q;
	logic                 read_alive_q;
	logic [KIND_W-1:0]    done_kind_q;

	logic                 in_grid;
	logic [RA_W-1:0]      cell_ra;
	logic [CA_W-1:0]      cell_ca;
	logic [GRID_COLS-1:0] rd_val;
	logic [GRID_COLS-1:0] next_row;
	logic [GRID_COLS-1:0] next_gen;
	logic [GRID_COLS-1:0] cell_wd;
	logic [GRID_COLS+1:0] pad_prev, pad_cur, pad_next;
	logic                 mem_we;
	logic [RA_W-1:0]      mem_wa, mem_ra;
	logic [GRID_COLS-1:0] mem_wd;

	function automatic logic [CNT_W-1:0] nb_count(input logic [7:0] v);
		logic [CNT_W-1:0] n;
		n = '0;
		for (int i = 0; i < 8; i++) begin
			n = n + CNT_W'(v[i]);
		end
		return n;
	endfunction

	assign in_grid = (32'(row_q) < 32'(GRID_ROWS)) && (32'(col_q) < 32'(GRID_COLS));
	assign cell_ra = RA_W'(row_q);
	assign cell_ca = CA_W'(col_q);
	assign rd_val  = rd_zero_s1 ? '0 : rd_data_s1;
	assign next_row = cmd.last ? '0 : rd_val;

	assign pad_prev = {1'b0, prev_q, 1'b0};
	assign pad_cur  = {1'b0, cur_q, 1'b0};
	assign pad_next = {1'b0, next_row, 1'b0};

	// all cells of a row update together from the buffered old rows
	for (genvar c = 0; c < GRID_COLS; c++) begin : g_cell
		logic [CNT_W-1:0] cnt;
		assign cnt = nb_count({pad_prev[c], pad_prev[c+1], pad_prev[c+2],
			pad_cur[c], pad_cur[c+2], pad_next[c], pad_next[c+1], pad_next[c+2]});
		assign next_gen[c] = cur_q[c] ?
			(cnt == rules.survive_a || cnt == rules.survive_b) :
			(cnt == rules.birth_a || cnt == rules.birth_b);
	end

	always_comb begin
		cell_wd          = rd_val;
		cell_wd[cell_ca] = wv_q;
	end

	assign mem_we = cmd.sweep | (cmd.push & (kind_q == REQ_WRITE) & in_grid);
	assign mem_wa = cmd.sweep ? sweep_row : cell_ra;
	assign mem_wd = cmd.sweep ? next_gen : cell_wd;
	assign mem_ra = cmd.rd_cell ? cell_ra : rd_row;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		if (cmd.rd_en) begin
			rd_data_s1 <= mem_q[mem_ra];
			rd_zero_s1 <= !row_valid_q[mem_ra];
		end
	end

	// rows never written read as dead
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (mem_we) begin
			row_valid_q[mem_wa] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= req_type;
			row_q  <= cell_row;
			col_q  <= cell_col;
			wv_q   <= write_alive;
		end
		if (cmd.clr_prev) begin
			prev_q <= '0;
		end else if (cmd.sweep) begin
			prev_q <= cur_q;
		end
		if (cmd.load_cur) begin
			cur_q <= rd_val;
		end else if (cmd.sweep) begin
			cur_q <= next_row;
		end
		if (cmd.push) begin
			read_alive_q <= (kind_q == REQ_READ) & in_grid & rd_val[cell_ca];
			done_kind_q  <= kind_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.push) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign st.slot_free = !rsp_valid_q | rsp_ready;
	assign rsp_valid    = rsp_valid_q;
	assign read_alive   = read_alive_q;
	assign done_kind    = done_kind_q;

endmodule

FILE: rtl/life_like_grid_automaton.sv
`timescale 1ns / 1ps
// top level of the life-like grid automaton
//
//   channel   dir   handshake              payload
//   req       in    req.valid/req.ready    req_type, cell_row, cell_col, write_alive
//   rsp       out   rsp.valid/rsp.ready    read_alive, done_kind
//   apb       in    psel/penable/pready    paddr, pwdata, pwrite, prdata
//
// read and write transactions step through accept, one row read, then write-back/result
// advance fills and loads the row buffers, then sweeps one grid row per cycle
// through the single row memory (prev/cur/next row buffers)
// reset clears the row valid bits, so the grid reads all dead with no clearing pass
// a result waits in the output register; the next request is taken once the
// controller is idle, and a full output register holds the controller in its last state
module life_like_grid_automaton import llga_pkg::*; #(
	parameter int GRID_ROWS = 16,
	parameter int GRID_COLS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	llga_req_if.sink              req,
	llga_rsp_if.source            rsp,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int RA_W = $clog2(GRID_ROWS);

	rule_cfg_t       rules;
	ctl_cmd_t        cmd;
	dp_status_t      st;
	logic [RA_W-1:0] rd_row;
	logic [RA_W-1:0] sweep_row;

	llga_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.rules   (rules)
	);

	llga_ctrl #(
		.GRID_ROWS (GRID_ROWS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_type  (req.req_type),
		.req_ready (req.ready),
		.st        (st),
		.cmd       (cmd),
		.rd_row    (rd_row),
		.sweep_row (sweep_row)
	);

	llga_datapath #(
		.GRID_ROWS (GRID_ROWS),
		.GRID_COLS (GRID_COLS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.rd_row      (rd_row),
		.sweep_row   (sweep_row),
		.st          (st),
		.rules       (rules),
		.req_type    (req.req_type),
		.cell_row    (req.cell_row),
		.cell_col    (req.cell_col),
		.write_alive (req.write_alive),
		.rsp_valid   (rsp.valid),
		.rsp_ready   (rsp.ready),
		.read_alive  (rsp.read_alive),
		.done_kind   (rsp.done_kind)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && (req.req_type == REQ_WRITE ||
			req.req_type == REQ_READ || req.req_type == REQ_ADVANCE)) |=> !req.ready)
		else $error("request taken while a transaction is in progress");

	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.sweep && cmd.push))
		else $error("sweep write and cell write in the same cycle");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> st.slot_free)
		else $error("result pushed into a full output register");

	a_sweep_ends_done: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.sweep && cmd.last) |=> (!req.ready && !cmd.sweep))
		else $error("sweep did not finish into the result state");

endmodule
